// ===== hw/rtl/tmp_pkg.sv =====
// shared types, constants and helper functions for the trapezoid motion profile
`timescale 1ns / 1ps
package tmp_pkg;

	localparam int SQRT_STEPS = 32;
	localparam int DIV_STEPS  = 64;
	localparam int CNT_W      = 6;

	localparam logic [2:0] REG_DISTANCE = 3'd0;
	localparam logic [2:0] REG_ACCEL    = 3'd1;
	localparam logic [2:0] REG_DECEL    = 3'd2;
	localparam logic [2:0] REG_VCAP     = 3'd3;

	localparam logic [30:0] LIMIT_RESET = 31'd65536;

	typedef enum logic [3:0] {
		PL_IDLE,
		PL_MUL,
		PL_SQRT,
		PL_TA,
		PL_TD,
		PL_DA,
		PL_DD,
		PL_TC,
		PL_SUM
	} plan_state_t;

	typedef enum logic [1:0] {
		PH_ACCEL,
		PH_COAST,
		PH_DECEL,
		PH_DONE
	} phase_t;

	function automatic logic [31:0] sat32(input logic [63:0] x);
		return (|x[63:32]) ? 32'hFFFF_FFFF : x[31:0];
	endfunction

	function automatic logic [30:0] at_least_one(input logic [30:0] x);
		return (x == 31'd0) ? 31'd1 : x;
	endfunction

	// apply sign to a magnitude and clamp to the signed 32-bit range
	function automatic logic [31:0] signed_out(input logic [63:0] mag, input logic neg);
		logic [63:0] m;
		if (neg) begin
			m = (mag > 64'h8000_0000) ? 64'h8000_0000 : mag;
			return (~m[31:0]) + 32'd1;
		end else begin
			return (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
		end
	endfunction

endpackage

// ===== hw/rtl/trapezoid_motion_profile.sv =====
// trapezoid motion profile: plan sequencer and four-stage sample evaluator
//
//  channel   signals                                  handshake
//  request   start, busy, sample_time                 taken when start && !busy
//  result    result_valid, position_out, velocity_out one-cycle strobe, no stall
//            accel_out, total_time
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data taken when valid && ready
//
// one request per cycle while busy is low; each result passes through stages s1 to s4.
// after reset and after each register write the planner runs once (busy high):
// a multiply, a bit-serial square root, then five divisions on the shared
// bit-serial divider and a sum; a zero peak velocity ends the plan after the root.
// cfg_ready is low while the planner runs, while start is high and while
// requests are in flight. results cannot be held off.
`timescale 1ns / 1ps
module trapezoid_motion_profile
	import tmp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] sample_time,
	output logic        result_valid,
	output logic [31:0] position_out,
	output logic [31:0] velocity_out,
	output logic [31:0] accel_out,
	output logic [31:0] total_time,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	// configuration registers
	logic [31:0] dist_q;
	logic [30:0] accel_q, decel_q, vcap_q;
	logic        plan_valid_q;

	logic [30:0] a_eff, d_eff, cap_eff, amin;
	logic [31:0] dm;
	logic        neg;
	logic        cfg_wr, accept;

	assign a_eff   = at_least_one(accel_q);
	assign d_eff   = at_least_one(decel_q);
	assign cap_eff = at_least_one(vcap_q);
	assign amin    = (a_eff < d_eff) ? a_eff : d_eff;
	assign neg     = dist_q[31];
	assign dm      = neg ? ((~dist_q) + 32'd1) : dist_q;

	// planner state and data
	plan_state_t pl_state_q, pl_state_d;
	logic [CNT_W-1:0] cnt_q;
	logic [63:0] xs_q;
	logic [32:0] srem_q;
	logic [31:0] sr_q;
	logic [63:0] dq_q;
	logic [31:0] dr_q, dd_q;
	logic [31:0] v_q, aend_q, cend_q, mend_q, rud_q, td_q;

	logic        valid_s1, valid_s2, valid_s3, valid_s4;

	assign cfg_ready = (pl_state_q == PL_IDLE) && !start
		&& !(valid_s1 || valid_s2 || valid_s3 || valid_s4);
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign busy      = !plan_valid_q || (pl_state_q != PL_IDLE);
	assign accept    = start && !busy;

	// square root digit step
	logic [34:0] s_remsh, s_trial;
	logic        s_ge;
	logic [34:0] s_rem_n;
	logic [31:0] s_r_n, v_new;
	logic        sqrt_last;

	assign s_remsh   = {srem_q, xs_q[63:62]};
	assign s_trial   = {1'b0, sr_q, 2'b01};
	assign s_ge      = (s_remsh >= s_trial);
	assign s_rem_n   = s_ge ? (s_remsh - s_trial) : s_remsh;
	assign s_r_n     = {sr_q[30:0], s_ge};
	assign v_new     = (s_r_n > {1'b0, cap_eff}) ? {1'b0, cap_eff} : s_r_n;
	assign sqrt_last = (cnt_q == CNT_W'(SQRT_STEPS - 1));

	// restoring divider step
	logic [32:0] d_rsh, d_diff;
	logic        d_ge;
	logic [31:0] d_rem_n;
	logic [63:0] d_quo_n;
	logic        div_last;

	assign d_rsh    = {dr_q, dq_q[63]};
	assign d_diff   = d_rsh - {1'b0, dd_q};
	assign d_ge     = (d_rsh >= {1'b0, dd_q});
	assign d_rem_n  = d_ge ? d_diff[31:0] : d_rsh[31:0];
	assign d_quo_n  = {dq_q[62:0], d_ge};
	assign div_last = (cnt_q == CNT_W'(DIV_STEPS - 1));

	// coast distance left after both ramps, and the phase end times
	logic [32:0] ramp_sum;
	logic [31:0] coast_dist;
	logic [32:0] cend_sum, mend_sum;

	assign ramp_sum   = {1'b0, rud_q} + {1'b0, d_quo_n[31:0]};
	assign coast_dist = (ramp_sum <= {1'b0, dm}) ? (dm - ramp_sum[31:0]) : 32'd0;
	assign cend_sum   = {1'b0, aend_q} + {1'b0, sat32(d_quo_n)};
	assign mend_sum   = {1'b0, cend_q} + {1'b0, td_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dist_q       <= '0;
			accel_q      <= LIMIT_RESET;
			decel_q      <= LIMIT_RESET;
			vcap_q       <= LIMIT_RESET;
			plan_valid_q <= 1'b0;
			pl_state_q   <= PL_IDLE;
			cnt_q        <= '0;
		end else begin
			pl_state_q <= pl_state_d;
			if (pl_state_q == PL_MUL || pl_state_d != pl_state_q) begin
				cnt_q <= '0;
			end else begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if ((pl_state_q == PL_SQRT && sqrt_last && v_new == 32'd0)
					|| pl_state_q == PL_SUM) begin
				plan_valid_q <= 1'b1;
			end
			if (cfg_wr) begin
				case (cfg_index)
					REG_DISTANCE: begin
						dist_q       <= cfg_data;
						plan_valid_q <= 1'b0;
					end
					REG_ACCEL: begin
						accel_q      <= cfg_data[30:0];
						plan_valid_q <= 1'b0;
					end
					REG_DECEL: begin
						decel_q      <= cfg_data[30:0];
						plan_valid_q <= 1'b0;
					end
					REG_VCAP: begin
						vcap_q       <= cfg_data[30:0];
						plan_valid_q <= 1'b0;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_comb begin
		pl_state_d = pl_state_q;
		case (pl_state_q)
			PL_IDLE: begin
				if (!plan_valid_q) pl_state_d = PL_MUL;
			end
			PL_MUL: pl_state_d = PL_SQRT;
			PL_SQRT: begin
				if (sqrt_last) pl_state_d = (v_new == 32'd0) ? PL_IDLE : PL_TA;
			end
			PL_TA: begin
				if (div_last) pl_state_d = PL_TD;
			end
			PL_TD: begin
				if (div_last) pl_state_d = PL_DA;
			end
			PL_DA: begin
				if (div_last) pl_state_d = PL_DD;
			end
			PL_DD: begin
				if (div_last) pl_state_d = PL_TC;
			end
			PL_TC: begin
				if (div_last) pl_state_d = PL_SUM;
			end
			PL_SUM: pl_state_d = PL_IDLE;
			default: pl_state_d = PL_IDLE;
		endcase
	end

	// planner datapath
	always_ff @(posedge clk) begin
		case (pl_state_q)
			PL_MUL: begin
				xs_q   <= {1'b0, 63'({32'd0, amin} * {31'd0, dm})};
				srem_q <= '0;
				sr_q   <= '0;
			end
			PL_SQRT: begin
				xs_q   <= {xs_q[61:0], 2'b00};
				srem_q <= s_rem_n[32:0];
				sr_q   <= s_r_n;
				if (sqrt_last) begin
					v_q <= v_new;
					if (v_new == 32'd0) begin
						aend_q <= '0;
						cend_q <= '0;
						mend_q <= '0;
						rud_q  <= '0;
					end
					dq_q <= {16'd0, v_new, 16'd0};
					dr_q <= '0;
					dd_q <= {1'b0, a_eff};
				end
			end
			PL_TA, PL_TD, PL_DA, PL_DD, PL_TC: begin
				if (!div_last) begin
					dq_q <= d_quo_n;
					dr_q <= d_rem_n;
				end else begin
					dr_q <= '0;
					case (pl_state_q)
						PL_TA: begin
							aend_q <= sat32(d_quo_n);
							dq_q   <= {16'd0, v_q, 16'd0};
							dd_q   <= {1'b0, d_eff};
						end
						PL_TD: begin
							td_q <= sat32(d_quo_n);
							dq_q <= v_q * v_q;
							dd_q <= {a_eff, 1'b0};
						end
						PL_DA: begin
							rud_q <= d_quo_n[31:0];
							dq_q  <= v_q * v_q;
							dd_q  <= {d_eff, 1'b0};
						end
						PL_DD: begin
							dq_q <= {16'd0, coast_dist, 16'd0};
							dd_q <= v_q;
						end
						PL_TC: begin
							cend_q <= sat32({31'd0, cend_sum});
						end
						default: begin
						end
					endcase
				end
			end
			PL_SUM: begin
				mend_q <= sat32({31'd0, mend_sum});
			end
			default: begin
			end
		endcase
	end

	// evaluation pipeline
	phase_t ph_s1, ph_s2, ph_s3;
	logic [31:0] opa_s1, opb_s1, mb_s1;
	logic [31:0] vel_s2, mb_s2;
	logic [47:0] cpart_s2, cpart_s3;
	logic [31:0] vel_s3;
	logic [63:0] prod2_s3;

	phase_t      ph_in;
	logic [63:0] prod1;
	logic [47:0] p16;
	logic [46:0] half;
	logic [63:0] pos_mag, acc_mag;
	logic        acc_neg;

	always_comb begin
		if (v_q == 32'd0 || sample_time > mend_q) begin
			ph_in = PH_DONE;
		end else if (sample_time <= aend_q) begin
			ph_in = PH_ACCEL;
		end else if (sample_time <= cend_q) begin
			ph_in = PH_COAST;
		end else begin
			ph_in = PH_DECEL;
		end
	end

	assign prod1 = opa_s1 * opb_s1;
	assign p16   = prod1[63:16];
	assign half  = prod2_s3[63:17];

	always_comb begin
		pos_mag = '0;
		acc_mag = '0;
		acc_neg = 1'b0;
		case (ph_s3)
			PH_ACCEL: begin
				pos_mag = {17'd0, half};
				acc_mag = {33'd0, a_eff};
			end
			PH_COAST: begin
				pos_mag = {32'd0, rud_q} + {16'd0, cpart_s3};
			end
			PH_DECEL: begin
				pos_mag = ({17'd0, half} <= {32'd0, dm}) ? ({32'd0, dm} - {17'd0, half}) : '0;
				acc_mag = {33'd0, d_eff};
				acc_neg = 1'b1;
			end
			PH_DONE: begin
				pos_mag = {32'd0, dm};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		// s1: phase pick and multiplier operands
		ph_s1 <= ph_in;
		case (ph_in)
			PH_ACCEL: begin
				opa_s1 <= {1'b0, a_eff};
				opb_s1 <= sample_time;
				mb_s1  <= sample_time;
			end
			PH_COAST: begin
				opa_s1 <= v_q;
				opb_s1 <= sample_time - aend_q;
				mb_s1  <= '0;
			end
			PH_DECEL: begin
				opa_s1 <= {1'b0, d_eff};
				opb_s1 <= mend_q - sample_time;
				mb_s1  <= mend_q - sample_time;
			end
			default: begin
				opa_s1 <= '0;
				opb_s1 <= '0;
				mb_s1  <= '0;
			end
		endcase
		// s2: velocity
		ph_s2    <= ph_s1;
		mb_s2    <= mb_s1;
		cpart_s2 <= p16;
		case (ph_s1)
			PH_ACCEL: vel_s2 <= p16[31:0];
			PH_COAST: vel_s2 <= v_q;
			PH_DECEL: vel_s2 <= (p16 > {16'd0, v_q}) ? v_q : p16[31:0];
			default:  vel_s2 <= '0;
		endcase
		// s3: ramp distance product
		ph_s3    <= ph_s2;
		vel_s3   <= vel_s2;
		cpart_s3 <= cpart_s2;
		prod2_s3 <= vel_s2 * mb_s2;
		// s4: sign and saturate
		position_out <= signed_out(pos_mag, neg);
		velocity_out <= signed_out({32'd0, vel_s3}, neg);
		accel_out    <= signed_out(acc_mag, neg != acc_neg);
		total_time   <= mend_q;
	end

	assign result_valid = valid_s4;

`ifndef SYNTHESIS
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##4 result_valid)
		else $error("request did not produce a result four cycles later");

	a_cfg_replan: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_wr && (cfg_index == REG_DISTANCE || cfg_index == REG_ACCEL
			|| cfg_index == REG_DECEL || cfg_index == REG_VCAP)) |=> busy)
		else $error("register write did not start a new plan");

	a_plan_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(pl_state_q != PL_IDLE) |-> (busy && !cfg_ready))
		else $error("planner running while block reports idle");
`endif

endmodule
